/* sv/trg_pkg.sv */
package trg_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int RAD_W    = 2 * SAMPLE_W;
	localparam int CS_W     = 22;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 16;

	localparam logic [31:0] CARRIER_MAX = 32'd4194303;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] CFG_THRESH_FRACTION = 3'd0;
	localparam logic [IDX_W-1:0] CFG_MIN_PULSE_WIDTH = 3'd1;
	localparam logic [IDX_W-1:0] CFG_QUIET_SAMPLES   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_PULSES_NEEDED   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_OPEN_LENGTH     = 3'd4;
	localparam logic [IDX_W-1:0] CFG_CARRIER_SPAN    = 3'd5;

	// Register reset values
	localparam logic [7:0]  RST_THRESH_FRACTION = 8'd223;
	localparam logic [15:0] RST_MIN_PULSE_WIDTH = 16'd12;
	localparam logic [15:0] RST_QUIET_SAMPLES   = 16'd50;
	localparam logic [7:0]  RST_PULSES_NEEDED   = 8'd3;
	localparam logic [15:0] RST_OPEN_LENGTH     = 16'd100;
	localparam logic [6:0]  RST_CARRIER_SPAN    = 7'd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_MUL_Q,
		ST_POW,
		ST_ROOT,
		ST_WSUM,
		ST_THR,
		ST_DECIDE,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_II,
		MS_QQ,
		MS_MAG,
		MS_THR
	} mul_sel_t;

	// Control from sequencer to the ring store
	typedef struct packed {
		logic re;
		logic we;
	} ring_ctl_t;

endpackage

/* sv/trg_root.sv */
module trg_root (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [trg_pkg::RAD_W-1:0]         radicand,
	output logic                              done,
	output logic [trg_pkg::SAMPLE_W-1:0]      root
);

	localparam int RW = trg_pkg::SAMPLE_W;
	localparam int CW = $clog2(RW);

	logic [trg_pkg::RAD_W-1:0] rad_q;
	logic [RW:0]               rem_q;
	logic [RW-1:0]             root_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [RW+2:0]             rem_sh;
	logic [RW+2:0]             trial;

	// One result bit per step: bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q, rad_q[trg_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= (RW+1)'(rem_sh - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= (RW+1)'(rem_sh);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* sv/trg_ring.sv */
module trg_ring #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trg_pkg::ring_ctl_t            ctl,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [trg_pkg::SAMPLE_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [trg_pkg::SAMPLE_W-1:0]  rdata
);

	localparam int FW = $clog2(DEPTH + 1);

	logic [trg_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [trg_pkg::SAMPLE_W-1:0] rd_q;
	logic                         vld_q;
	logic [FW-1:0]                fill_q;

	// Writes walk the addresses in order from zero, so an entry below the
	// fill count has been written; anything at or above it reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (ctl.we && fill_q != FW'(DEPTH))
				fill_q <= fill_q + 1'b1;
			if (ctl.re)
				vld_q <= FW'(raddr) < fill_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we)
			mem[waddr] <= wdata;
		if (ctl.re)
			rd_q <= mem[raddr];
	end

	assign rdata = vld_q ? rd_q : '0;

endmodule

/* sv/tag_response_gate_top.sv */
// Tag response gate.
// Input words arrive on s_axis (tdata = in_i, in_q). Each sample's magnitude
// is the floored square root of I*I+Q*Q, tracked against a moving average over
// a window of WINDOW_LEN magnitudes. Edges and pulses are counted while the gate
// is closed; once the reply preamble is seen the gate opens and the opening
// sample and those after it, open_length in all (at least two), go out on
// m_axis. tuser marks the opening sample, tlast the final one, which also
// carries the summed carrier magnitude.
// Configuration writes go over cfg (index, data), always ready; write only while
// the block is idle.
// Each sample passes through the 16-step shift/subtract square root unit
// and one shared multiplier used for I*I, Q*Q, the window scale and the
// threshold before its word reaches the output register; the next sample is
// taken only once the previous one is finished. The opening sample also sums
// min(carrier_span, WINDOW_LEN) reads of the window store. s_axis_tready is
// high only while idle. A finished word waits in the output register while
// m_axis_tready is low; the next sample is worked on and stalls only when its
// own word is ready to load. Reset clears all control state, registers go to
// defaults, the window reads as zero until written; no clearing pass is needed.
module tag_response_gate_top #(
	parameter int WINDOW_LEN = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // in_i, in_q
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [55:0]                    m_axis_tdata,  // out_i, out_q, carrier_sum
	output logic                           m_axis_tuser,  // burst_first
	output logic                           m_axis_tlast,  // burst_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [trg_pkg::IDX_W-1:0]      cfg_index,
	input  logic [trg_pkg::CFG_W-1:0]      cfg_data
);

	localparam int SW     = trg_pkg::SAMPLE_W;
	localparam int AW     = $clog2(WINDOW_LEN);
	localparam int SUM_W  = SW + AW;
	localparam int SPW    = $clog2(WINDOW_LEN + 1);
	localparam int MA_W   = SUM_W + 1;
	localparam int MB_W   = SW + 1;
	localparam int PROD_W = MA_W + MB_W;
	localparam int CS_W   = trg_pkg::CS_W;

	trg_pkg::state_t   state_q, state_n;
	trg_pkg::mul_sel_t mul_sel;
	trg_pkg::ring_ctl_t ring_ctl;

	// configuration
	logic [7:0]  thresh_q;
	logic [15:0] min_pw_q;
	logic [15:0] quiet_q;
	logic [7:0]  need_q;
	logic [15:0] open_len_q;
	logic [6:0]  span_cfg_q;

	// tracking state
	logic [AW-1:0]    pos_q;
	logic [SUM_W-1:0] wsum_q;
	logic [CS_W-1:0]  held_q;
	logic             open_q;
	logic             lvl_q;
	logic [15:0]      sc_q;
	logic [7:0]       pc_q;

	// per-sample work registers
	logic signed [SW-1:0]      i_q, q_q;
	logic [SW-1:0]             old_q;
	logic [SW-1:0]             mag_q;
	logic [trg_pkg::RAD_W-1:0] pow_q;
	logic signed [PROD_W-1:0]  mul_q;
	logic [PROD_W-1:0]         lhs_q;
	logic                      res_q, first_q, last_q;
	logic [CS_W-1:0]           rcar_q;

	// carrier sum walk
	logic [AW-1:0]    sidx_q;
	logic [SPW-1:0]   sleft_q;
	logic             pend_q;
	logic [SUM_W-1:0] acc_q;

	// output register
	logic              ovld_q;
	logic [SW-1:0]     oi_q, oq_q;
	logic              ofirst_q, olast_q;
	logic [CS_W-1:0]   ocar_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic                   root_start;
	logic                   root_done;
	logic [SW-1:0]          root;
	logic [AW-1:0]          ring_raddr;
	logic [SW-1:0]          ring_rdata;
	logic [AW-1:0]          sidx_n;
	logic                   sum_done;
	logic                   fin_go;
	logic                   accept;

	// decision logic
	logic        lt, gt;
	logic [15:0] sc_inc, sc_n;
	logic [7:0]  pc_n;
	logic        lvl_n, open_n;
	logic        r_valid, r_first, r_last, opening;
	logic [CS_W-1:0] r_car;
	logic [SPW-1:0]  span;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign sidx_n    = (sidx_q == '0) ? AW'(WINDOW_LEN - 1) : sidx_q - 1'b1;
	assign sum_done  = (sleft_q == '0) && !pend_q;
	assign fin_go    = !res_q || !ovld_q || m_axis_tready;
	assign span      = (32'(span_cfg_q) < WINDOW_LEN) ? SPW'(span_cfg_q) : SPW'(WINDOW_LEN);

	trg_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (pow_q + mul_q[trg_pkg::RAD_W-1:0]),
		.done     (root_done),
		.root     (root)
	);

	trg_ring #(
		.DEPTH (WINDOW_LEN)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.waddr  (pos_q),
		.wdata  (mag_q),
		.raddr  (ring_raddr),
		.rdata  (ring_rdata)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			trg_pkg::ST_IDLE:   if (accept) state_n = trg_pkg::ST_MUL_I;
			trg_pkg::ST_MUL_I:  state_n = trg_pkg::ST_MUL_Q;
			trg_pkg::ST_MUL_Q:  state_n = trg_pkg::ST_POW;
			trg_pkg::ST_POW:    state_n = trg_pkg::ST_ROOT;
			trg_pkg::ST_ROOT:   if (root_done) state_n = trg_pkg::ST_WSUM;
			trg_pkg::ST_WSUM:   state_n = trg_pkg::ST_THR;
			trg_pkg::ST_THR:    state_n = trg_pkg::ST_DECIDE;
			trg_pkg::ST_DECIDE: state_n = opening ? trg_pkg::ST_SUM : trg_pkg::ST_FIN;
			trg_pkg::ST_SUM:    if (sum_done) state_n = trg_pkg::ST_FIN;
			trg_pkg::ST_FIN:    if (fin_go) state_n = trg_pkg::ST_IDLE;
			default:            state_n = trg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mul_sel       = trg_pkg::MS_NONE;
		root_start    = 1'b0;
		ring_ctl      = '0;
		ring_raddr    = pos_q;
		case (state_q)
			trg_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				ring_ctl.re   = s_axis_tvalid;
			end
			trg_pkg::ST_MUL_I: mul_sel = trg_pkg::MS_II;
			trg_pkg::ST_MUL_Q: mul_sel = trg_pkg::MS_QQ;
			trg_pkg::ST_POW:   root_start = 1'b1;
			trg_pkg::ST_WSUM:  mul_sel = trg_pkg::MS_MAG;
			trg_pkg::ST_THR:   mul_sel = trg_pkg::MS_THR;
			trg_pkg::ST_SUM: begin
				ring_ctl.re = sleft_q != '0;
				ring_raddr  = sidx_n;
			end
			trg_pkg::ST_FIN:   ring_ctl.we = fin_go;
			default: ;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mul_sel)
			trg_pkg::MS_II: begin
				mul_a = MA_W'(i_q);
				mul_b = MB_W'(i_q);
			end
			trg_pkg::MS_QQ: begin
				mul_a = MA_W'(q_q);
				mul_b = MB_W'(q_q);
			end
			trg_pkg::MS_MAG: begin
				mul_a = signed'(MA_W'(root));
				mul_b = signed'(MB_W'(WINDOW_LEN));
			end
			trg_pkg::MS_THR: begin
				mul_a = signed'(MA_W'(wsum_q));
				mul_b = signed'(MB_W'(thresh_q));
			end
			default: ;
		endcase
	end

	// edge, pulse and gate decision
	assign lt     = lhs_q < PROD_W'(mul_q);
	assign gt     = lhs_q > PROD_W'(mul_q);
	assign sc_inc = (sc_q != 16'hFFFF) ? sc_q + 1'b1 : sc_q;

	always_comb begin
		sc_n    = sc_inc;
		pc_n    = pc_q;
		lvl_n   = lvl_q;
		open_n  = open_q;
		r_valid = 1'b0;
		r_first = 1'b0;
		r_last  = 1'b0;
		r_car   = '0;
		opening = 1'b0;
		if (!open_q) begin
			if (lt && lvl_q) begin
				sc_n  = '0;
				lvl_n = 1'b0;
			end else if (gt && !lvl_q) begin
				lvl_n = 1'b1;
				if (sc_inc > min_pw_q)
					pc_n = (pc_q != 8'hFF) ? pc_q + 1'b1 : pc_q;
				else
					pc_n = '0;
				sc_n = '0;
			end
			if (sc_n > quiet_q && lvl_n && pc_n > need_q) begin
				open_n  = 1'b1;
				pc_n    = '0;
				sc_n    = 16'd1;
				r_valid = 1'b1;
				r_first = 1'b1;
				opening = 1'b1;
			end
		end else begin
			r_valid = 1'b1;
			if (sc_inc >= open_len_q) begin
				r_last = 1'b1;
				r_car  = held_q;
				open_n = 1'b0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= trg_pkg::ST_IDLE;
			thresh_q   <= trg_pkg::RST_THRESH_FRACTION;
			min_pw_q   <= trg_pkg::RST_MIN_PULSE_WIDTH;
			quiet_q    <= trg_pkg::RST_QUIET_SAMPLES;
			need_q     <= trg_pkg::RST_PULSES_NEEDED;
			open_len_q <= trg_pkg::RST_OPEN_LENGTH;
			span_cfg_q <= trg_pkg::RST_CARRIER_SPAN;
			pos_q      <= '0;
			wsum_q     <= '0;
			held_q     <= '0;
			open_q     <= 1'b0;
			lvl_q      <= 1'b0;
			sc_q       <= '0;
			pc_q       <= '0;
			res_q      <= 1'b0;
			sleft_q    <= '0;
			pend_q     <= 1'b0;
			ovld_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					trg_pkg::CFG_THRESH_FRACTION: thresh_q   <= cfg_data[7:0];
					trg_pkg::CFG_MIN_PULSE_WIDTH: min_pw_q   <= cfg_data;
					trg_pkg::CFG_QUIET_SAMPLES:   quiet_q    <= cfg_data;
					trg_pkg::CFG_PULSES_NEEDED:   need_q     <= cfg_data[7:0];
					trg_pkg::CFG_OPEN_LENGTH:     open_len_q <= cfg_data;
					trg_pkg::CFG_CARRIER_SPAN:    span_cfg_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == trg_pkg::ST_WSUM)
				wsum_q <= wsum_q - SUM_W'(old_q) + SUM_W'(root);
			if (state_q == trg_pkg::ST_DECIDE) begin
				sc_q    <= sc_n;
				pc_q    <= pc_n;
				lvl_q   <= lvl_n;
				open_q  <= open_n;
				res_q   <= r_valid;
				sleft_q <= span;
				pend_q  <= 1'b0;
			end
			if (state_q == trg_pkg::ST_SUM) begin
				pend_q <= ring_ctl.re;
				if (ring_ctl.re)
					sleft_q <= sleft_q - 1'b1;
				if (sum_done)
					held_q <= (32'(acc_q) > trg_pkg::CARRIER_MAX) ?
						CS_W'(trg_pkg::CARRIER_MAX) : CS_W'(acc_q);
			end
			if (state_q == trg_pkg::ST_FIN && fin_go)
				pos_q <= (pos_q == AW'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
			// load this sample's word, else drain the output register
			if (state_q == trg_pkg::ST_FIN && fin_go && res_q)
				ovld_q <= 1'b1;
			else if (m_axis_tready)
				ovld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q <= s_axis_tdata[15:0];
			q_q <= s_axis_tdata[31:16];
		end
		if (mul_sel != trg_pkg::MS_NONE)
			mul_q <= mul_a * mul_b;
		case (state_q)
			trg_pkg::ST_MUL_I: old_q <= ring_rdata;
			trg_pkg::ST_MUL_Q: pow_q <= mul_q[trg_pkg::RAD_W-1:0];
			trg_pkg::ST_WSUM:  mag_q <= root;
			trg_pkg::ST_THR:   lhs_q <= {mul_q[PROD_W-9:0], 8'd0};
			trg_pkg::ST_DECIDE: begin
				first_q <= r_first;
				last_q  <= r_last;
				rcar_q  <= r_car;
				sidx_q  <= pos_q;
				acc_q   <= '0;
			end
			trg_pkg::ST_SUM: begin
				if (ring_ctl.re)
					sidx_q <= sidx_n;
				if (pend_q)
					acc_q <= acc_q + SUM_W'(ring_rdata);
			end
			default: ;
		endcase
		if (state_q == trg_pkg::ST_FIN && fin_go && res_q) begin
			oi_q     <= i_q;
			oq_q     <= q_q;
			ofirst_q <= first_q;
			olast_q  <= last_q;
			ocar_q   <= rcar_q;
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {2'b00, ocar_q, oq_q, oi_q};
	assign m_axis_tuser  = ofirst_q;
	assign m_axis_tlast  = olast_q;

	a_open_no_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> pc_q == '0)
		else $error("pulse count not cleared while gate open");

	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == trg_pkg::ST_ROOT)
		else $error("square root finished outside its wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == trg_pkg::ST_MUL_I)
		else $error("accepted word did not start the sequence");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
		else $error("opening word flagged as last");

	a_carrier_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[53:32] == '0)
		else $error("carrier sum on a word that is not last");

endmodule
